// ----- src/xee_pkg.sv -----
`default_nettype none
package xee_pkg;

	localparam int WinDepth = 9;
	localparam int CntW     = $clog2(WinDepth + 1);
	localparam int VerbW    = 4;
	localparam int MaxSeq   = 6;
	localparam int LenW     = $clog2(MaxSeq + 1);

	localparam logic [CntW-1:0] WinFull = CntW'(WinDepth);

	localparam logic [7:0] ChAmp  = 8'h26;
	localparam logic [7:0] ChLt   = 8'h3C;
	localparam logic [7:0] ChGt   = 8'h3E;
	localparam logic [7:0] ChApos = 8'h27;
	localparam logic [7:0] ChQuot = 8'h22;

	typedef logic [0:WinDepth-1][7:0] win_t;
	typedef logic [0:MaxSeq-1][7:0]   seq_buf_t;

	typedef enum logic [2:0] {
		SEQ_ONE,
		SEQ_AMP,
		SEQ_LT,
		SEQ_GT,
		SEQ_APOS,
		SEQ_QUOT
	} seq_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_beat_t;

	// what the head decision leaves behind
	typedef struct packed {
		seq_t             code;
		logic             in_cdata;
		logic [VerbW-1:0] verb;
	} decision_t;

	// one expansion handed to the output stage
	typedef struct packed {
		seq_t       code;
		logic [7:0] head;
		logic       last;
	} emit_req_t;

endpackage
`default_nettype wire

// ----- src/xee_decide.sv -----
`default_nettype none
module xee_decide (
	input  wire  xee_pkg::win_t                 win,
	input  wire  logic [xee_pkg::CntW-1:0]      count,
	input  wire  logic                          sec_open,
	input  wire  logic [xee_pkg::VerbW-1:0]     verb,
	input  wire  logic                          aware,
	output xee_pkg::decision_t                  dec
);

	localparam xee_pkg::win_t PatAmp   = {"&amp;",  {4{8'h00}}};
	localparam xee_pkg::win_t PatLt    = {"&lt;",   {5{8'h00}}};
	localparam xee_pkg::win_t PatGt    = {"&gt;",   {5{8'h00}}};
	localparam xee_pkg::win_t PatApos  = {"&apos;", {3{8'h00}}};
	localparam xee_pkg::win_t PatQuot  = {"&quot;", {3{8'h00}}};
	localparam xee_pkg::win_t PatOpen  = "<![CDATA[";
	localparam xee_pkg::win_t PatClose = {"]]>",    {6{8'h00}}};

	// prefix match, limited to the bytes actually held
	function automatic logic starts(xee_pkg::win_t w, logic [xee_pkg::CntW-1:0] cnt,
			xee_pkg::win_t pat, logic [xee_pkg::CntW-1:0] len);
		logic ok;
		ok = (len <= cnt);
		for (int i = 0; i < xee_pkg::WinDepth; i++) begin
			if (xee_pkg::CntW'(i) < len && w[i] != pat[i]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	logic [7:0] head;
	logic       m_amp, m_lt, m_gt, m_apos, m_quot, m_open, m_close;

	assign head    = win[0];
	assign m_amp   = starts(win, count, PatAmp,   xee_pkg::CntW'(5));
	assign m_lt    = starts(win, count, PatLt,    xee_pkg::CntW'(4));
	assign m_gt    = starts(win, count, PatGt,    xee_pkg::CntW'(4));
	assign m_apos  = starts(win, count, PatApos,  xee_pkg::CntW'(6));
	assign m_quot  = starts(win, count, PatQuot,  xee_pkg::CntW'(6));
	assign m_open  = starts(win, count, PatOpen,  xee_pkg::CntW'(9));
	assign m_close = starts(win, count, PatClose, xee_pkg::CntW'(3));

	always_comb begin
		dec.code     = xee_pkg::SEQ_ONE;
		dec.in_cdata = sec_open;
		dec.verb     = verb;
		if (verb != '0) begin
			dec.verb = verb - 1'b1;
		end else if (sec_open) begin
			if (m_close) begin
				dec.verb     = xee_pkg::VerbW'(2);
				dec.in_cdata = 1'b0;
			end
		end else if (aware && m_open) begin
			dec.verb     = xee_pkg::VerbW'(8);
			dec.in_cdata = 1'b1;
		end else if (m_amp) begin
			dec.verb = xee_pkg::VerbW'(4);
		end else if (m_lt || m_gt) begin
			dec.verb = xee_pkg::VerbW'(3);
		end else if (m_apos || m_quot) begin
			dec.verb = xee_pkg::VerbW'(5);
		end else begin
			case (head)
				xee_pkg::ChAmp:  dec.code = xee_pkg::SEQ_AMP;
				xee_pkg::ChLt:   dec.code = xee_pkg::SEQ_LT;
				xee_pkg::ChGt:   dec.code = xee_pkg::SEQ_GT;
				xee_pkg::ChApos: dec.code = xee_pkg::SEQ_APOS;
				xee_pkg::ChQuot: dec.code = xee_pkg::SEQ_QUOT;
				default:         dec.code = xee_pkg::SEQ_ONE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/xee_emit.sv -----
`default_nettype none
module xee_emit (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 load,
	input  wire  xee_pkg::emit_req_t   req,
	output logic                       can_load,
	output logic                       out_valid,
	input  wire  logic                 out_ready,
	output xee_pkg::out_beat_t         out_data
);

	function automatic xee_pkg::seq_buf_t seq_bytes(xee_pkg::seq_t code, logic [7:0] head);
		xee_pkg::seq_buf_t b;
		unique case (code)
			xee_pkg::SEQ_AMP:  b = {"&amp;", 8'h00};
			xee_pkg::SEQ_LT:   b = {"&lt;", 16'h0000};
			xee_pkg::SEQ_GT:   b = {"&gt;", 16'h0000};
			xee_pkg::SEQ_APOS: b = "&apos;";
			xee_pkg::SEQ_QUOT: b = "&quot;";
			default:           b = {head, 40'h0};
		endcase
		return b;
	endfunction

	function automatic logic [xee_pkg::LenW-1:0] seq_len(xee_pkg::seq_t code);
		logic [xee_pkg::LenW-1:0] n;
		unique case (code)
			xee_pkg::SEQ_AMP:                   n = xee_pkg::LenW'(5);
			xee_pkg::SEQ_LT, xee_pkg::SEQ_GT:   n = xee_pkg::LenW'(4);
			xee_pkg::SEQ_APOS, xee_pkg::SEQ_QUOT: n = xee_pkg::LenW'(6);
			default:                            n = xee_pkg::LenW'(1);
		endcase
		return n;
	endfunction

	xee_pkg::seq_buf_t        buf_q;
	logic [xee_pkg::LenW-1:0] left_q;
	logic                     last_q;
	logic                     final_beat;

	assign out_valid         = (left_q != '0);
	assign final_beat        = (left_q == xee_pkg::LenW'(1));
	assign can_load          = !out_valid || (final_beat && out_ready);
	assign out_data.out_byte = buf_q[0];
	assign out_data.out_last = last_q && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= seq_len(req.code);
		end else if (out_valid && out_ready) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= seq_bytes(req.code, req.head);
			last_q <= req.last;
		end else if (out_valid && out_ready) begin
			buf_q <= {buf_q[1:xee_pkg::MaxSeq-1], 8'h00};
		end
	end

endmodule
`default_nettype wire

// ----- src/xml_entity_escaper_cdata.sv -----
`default_nettype none
// Streaming XML escaper with CDATA pass-through.
//
// text: one input byte per beat (in_byte, in_last). esc: one escaped byte per
// beat (out_byte, out_last). cfg: single-bit cdata_aware write, always ready.
//
// Bytes collect in a 9-byte lookahead window. Once nine are held, the head is
// decided and its expansion (1 to 6 bytes) loads the output buffer; a plain
// byte follows another in every cycle while esc is ready; an entity expansion
// holds text_ready low until its final byte is taken. The output buffer width
// of one byte per cycle sets the rate.
// esc_valid rises once the ninth beat of a string, or its in_last beat if
// sooner, is registered and the head's expansion has loaded left_q. in_last
// starts a drain: text_ready stays low while every held byte is decided and
// expanded; out_last marks the final byte of it. A stall on esc fills the
// window and then backpressures text; nothing is dropped. Reset empties the
// window, closes any CDATA section and sets cdata_aware. Write cfg only while the block is idle.
module xml_entity_escaper_cdata (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                text_valid,
	output logic                      text_ready,
	input  wire  xee_pkg::in_beat_t   text,
	output logic                      esc_valid,
	input  wire  logic                esc_ready,
	output xee_pkg::out_beat_t        esc,
	input  wire  logic                cfg_valid,
	output logic                      cfg_ready,
	input  wire  logic                cfg_data
);

	// window and control state
	xee_pkg::win_t                win_q, win_d;
	logic [xee_pkg::CntW-1:0]     count_q, count_d;
	logic                         draining_q;
	logic                         cdata_q;
	logic [xee_pkg::VerbW-1:0]    verb_q;
	logic                         aware_q;

	logic                         take;      // input beat accepted
	logic                         fire;      // head decided this cycle
	logic                         drain_end; // final head of a drain
	logic                         can_load;
	logic [xee_pkg::CntW-1:0]     wr_pos;
	xee_pkg::decision_t           dec;
	xee_pkg::emit_req_t           req;

	assign cfg_ready = 1'b1;

	// Decide when the window is full, or whenever draining; only if the
	// output buffer can take the expansion now.
	assign fire = can_load &&
		(draining_q ? (count_q != '0) : (count_q == xee_pkg::WinFull));
	assign drain_end = fire && draining_q && (count_q == xee_pkg::CntW'(1));

	// A full window frees a slot in the same cycle its head leaves.
	assign text_ready = !draining_q && ((count_q != xee_pkg::WinFull) || fire);
	assign take       = text_valid && text_ready;

	xee_decide u_decide (
		.win      (win_q),
		.count    (count_q),
		.sec_open (cdata_q),
		.verb     (verb_q),
		.aware    (aware_q),
		.dec      (dec)
	);

	assign req.code = dec.code;
	assign req.head = win_q[0];
	assign req.last = drain_end;

	xee_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.req       (req),
		.can_load  (can_load),
		.out_valid (esc_valid),
		.out_ready (esc_ready),
		.out_data  (esc)
	);

	// Shift on a decision, then drop the new byte at the tail.
	assign wr_pos = fire ? (count_q - 1'b1) : count_q;

	always_comb begin
		for (int i = 0; i < xee_pkg::WinDepth; i++) begin
			if (fire && i < xee_pkg::WinDepth - 1) begin
				win_d[i] = win_q[i + 1];
			end else begin
				win_d[i] = win_q[i];
			end
			if (take && wr_pos == xee_pkg::CntW'(i)) begin
				win_d[i] = text.in_byte;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (fire && !take) begin
			count_d = count_q - 1'b1;
		end else if (take && !fire) begin
			count_d = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			draining_q <= 1'b0;
			cdata_q    <= 1'b0;
			verb_q     <= '0;
			aware_q    <= 1'b1;
		end else begin
			count_q <= count_d;
			if (cfg_valid && cfg_ready) begin
				aware_q <= cfg_data;
			end
			// end of string: next one starts outside any section
			if (drain_end) begin
				draining_q <= 1'b0;
				cdata_q    <= 1'b0;
				verb_q     <= '0;
			end else if (fire) begin
				cdata_q <= dec.in_cdata;
				verb_q  <= dec.verb;
			end
			if (take && text.in_last) begin
				draining_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/xee_checker.sv -----
`default_nettype none
module xee_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                text_valid,
	input wire logic                text_ready,
	input wire xee_pkg::in_beat_t   text,
	input wire logic                esc_valid,
	input wire logic                esc_ready,
	input wire xee_pkg::out_beat_t  esc,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready,
	input wire logic                cfg_data
);

	// hold a stalled output beat
	a_esc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(esc_valid && !esc_ready) |=> (esc_valid && $stable(esc)))
		else $error("esc beat changed while stalled");

	// a closing beat starts a drain, which blocks text
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && text_ready && text.in_last) |=> !text_ready)
		else $error("text accepted right after a last beat");

	// blocked with nothing pending on esc means a drain is about to emit
	a_no_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		(!text_ready && !esc_valid) |=> esc_valid)
		else $error("text blocked with no output in progress");

	// configuration never waits
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write stalled");

endmodule

bind xml_entity_escaper_cdata xee_checker u_xee_checker (.*);
`default_nettype wire

// ----- verif/tb_xml_entity_escaper_cdata.sv -----
`timescale 1ns / 100ps
module tb_xml_entity_escaper_cdata;
	import xee_pkg::*;

	// Run bounds: the cycle limit covers every beat expanding to six bytes,
	// each byte stalled by the longest ready drop, plus every drain, many times over.
	localparam int CycleLimit = 200000;
	localparam int SettleCycles = 16;
	localparam int PhaseBeats = 35;

	// Patterns the escaper recognizes at the head of its window
	localparam string EntAmp    = "&amp;";
	localparam string EntLt     = "&lt;";
	localparam string EntGt     = "&gt;";
	localparam string EntApos   = "&apos;";
	localparam string EntQuot   = "&quot;";
	localparam string OpenMark  = "<![CDATA[";
	localparam string CloseMark = "]]>";

	// One directed string: txt holds n bytes right-justified, exp holds the
	// escaped text when it is plain to see (en > 0), else the predictor decides.
	typedef struct packed {
		int           n;
		logic [255:0] txt;
		int           en;
		logic [255:0] exp;
	} text_row_t;

	localparam int NumRows = 5;
	text_row_t rows [0:NumRows-1] = '{
		'{2, "\000\377", 2, "\000\377"},
		'{5, "&<>'\"", 25, "&amp;&lt;&gt;&apos;&quot;"},
		'{4, "&lt;", 4, "&lt;"},
		'{14, "<![CDATA[<]]>'", 19, "<![CDATA[<]]>&apos;"},
		'{1, "x", 0, ""}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      text_valid = 1'b0;
	logic      text_ready;
	in_beat_t  text = '0;
	logic      esc_valid;
	logic      esc_ready = 1'b1;
	out_beat_t esc;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	// Side band that travels with each text beat: which directed row it
	// belongs to (-1 for random text) and whether it opens that row.
	int beat_row = -1;
	bit beat_first = 1'b0;

	// Escaper copy: pending window, section and copy state, register
	logic [7:0] pend [0:WinDepth-1];
	int         pend_n = 0;
	bit         in_sec = 1'b0;
	int         copy_left = 0;
	bit         aware_q = 1'b1;

	out_beat_t  fresh [$];
	out_beat_t  esc_due [$];
	logic [7:0] script [$];

	out_beat_t want;
	bit        calm = 1'b0;
	int        esc_hold = 0;
	int        hold_draw;
	int        fails = 0;
	int        beats_in = 0;
	int        bytes_out = 0;
	int        strings_sent = 0;
	int        cfg_writes = 0;
	int        cycles = 0;

	xml_entity_escaper_cdata dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text      (text),
		.esc_valid (esc_valid),
		.esc_ready (esc_ready),
		.esc       (esc),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Escaper prediction
	// ---------------------------------------------------------------

	// True when the pending bytes start with pat; only held bytes count.
	function automatic bit front_is(input string pat);
		if (pat.len() > pend_n)
			return 1'b0;
		for (int i = 0; i < pat.len(); i++)
			if (pend[i] != pat[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int entity_at_front();
		if (front_is(EntAmp)) return 5;
		if (front_is(EntLt)) return 4;
		if (front_is(EntGt)) return 4;
		if (front_is(EntApos)) return 6;
		if (front_is(EntQuot)) return 6;
		return 0;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		fresh.push_back(out_beat_t'{out_byte: b, out_last: 1'b0});
	endfunction

	function automatic void emit_str(input string s);
		for (int i = 0; i < s.len(); i++)
			emit_byte(s[i]);
	endfunction

	// Decide the front byte, emit its expansion and retire it.
	function automatic void settle_front();
		logic [7:0] h;
		int         ent;
		h = pend[0];
		ent = (h == ChAmp) ? entity_at_front() : 0;
		if (copy_left > 0) begin
			copy_left--;
			emit_byte(h);
		end else if (in_sec) begin
			// look for the close marker only once the open one is copied
			if (front_is(CloseMark)) begin
				copy_left = 2;
				in_sec = 1'b0;
			end
			emit_byte(h);
		end else if (aware_q && front_is(OpenMark)) begin
			copy_left = 8;
			in_sec = 1'b1;
			emit_byte(h);
		end else if (ent > 0) begin
			// a complete entity passes through untouched
			copy_left = ent - 1;
			emit_byte(h);
		end else begin
			case (h)
				ChAmp:   emit_str(EntAmp);
				ChLt:    emit_str(EntLt);
				ChGt:    emit_str(EntGt);
				ChApos:  emit_str(EntApos);
				ChQuot:  emit_str(EntQuot);
				default: emit_byte(h);
			endcase
		end
		for (int i = 0; i < WinDepth - 1; i++)
			pend[i] = pend[i + 1];
		pend[WinDepth - 1] = 8'h00;
		if (pend_n > 0)
			pend_n--;
	endfunction

	// Take one text beat; whatever it releases lands in fresh.
	function automatic void feed_text(input in_beat_t b);
		if (pend_n < WinDepth) begin
			pend[pend_n] = b.in_byte;
			pend_n++;
		end
		if (b.in_last) begin
			// drain the window and start the next string clean
			while (pend_n > 0)
				settle_front();
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].out_last = 1'b1;
			in_sec = 1'b0;
			copy_left = 0;
		end else if (pend_n >= WinDepth) begin
			settle_front();
		end
	endfunction

	// ---------------------------------------------------------------
	// Watch all three channels at the clock edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			aware_q = cfg_data;
		if (text_valid && text_ready) begin
			beats_in++;
			fresh.delete();
			feed_text(text);
			if (beat_row >= 0 && rows[beat_row].en > 0) begin
				// table row: book the typed text once, drop the prediction
				if (beat_first)
					for (int k = 0; k < rows[beat_row].en; k++)
						esc_due.push_back(out_beat_t'{
							out_byte: rows[beat_row].exp[8 * (rows[beat_row].en - 1 - k) +: 8],
							out_last: (k == rows[beat_row].en - 1)});
			end else begin
				foreach (fresh[k])
					esc_due.push_back(fresh[k]);
			end
		end
		if (esc_valid && esc_ready) begin
			bytes_out++;
			if (esc_due.size() == 0) begin
				$error("esc beat with nothing due: out_byte %h out_last %b",
					esc.out_byte, esc.out_last);
				fails++;
			end else begin
				want = esc_due.pop_front();
				if (esc.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, esc.out_byte);
					fails++;
				end
				if (esc.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, esc.out_last);
					fails++;
				end
			end
		end
	end

	// Output side: after each beat, drop ready for a randomly drawn hold (hold_draw), unless calm.
	always @(posedge clk) begin
		if (esc_valid && esc_ready) begin
			hold_draw = calm ? 0 : $urandom_range(0, 3);
			if (hold_draw > 0) begin
				esc_ready <= 1'b0;
				esc_hold <= hold_draw;
			end
		end else if (!esc_ready) begin
			if (esc_hold <= 1)
				esc_ready <= 1'b1;
			esc_hold <= esc_hold - 1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Offer one text beat after a random gap and hold it until taken.
	task automatic send_text(input logic [7:0] b, input logic l, input int row,
			input bit first);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text <= in_beat_t'{in_byte: b, in_last: l};
		beat_row <= row;
		beat_first <= first;
		do @(posedge clk); while (!text_ready);
	endtask

	// Wait out every due byte, then let the window absorb what is left.
	task automatic settle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (esc_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_aware(input logic v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			script.push_back(s[i]);
	endfunction

	// Build one random string, mostly out of entities and markers so the
	// copy and section paths get exercised, with noise mixed in.
	function automatic void make_text();
		int target;
		int cut;
		script.delete();
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
		while (script.size() < target) begin
			case ($urandom_range(0, 11))
				0: case ($urandom_range(0, 4))
					0: add_str(EntAmp);
					1: add_str(EntLt);
					2: add_str(EntGt);
					3: add_str(EntApos);
					default: add_str(EntQuot);
				endcase
				1: case ($urandom_range(0, 4))
					0: script.push_back(ChAmp);
					1: script.push_back(ChLt);
					2: script.push_back(ChGt);
					3: script.push_back(ChApos);
					default: script.push_back(ChQuot);
				endcase
				2, 3: add_str(OpenMark);
				4: add_str(CloseMark);
				5: begin
					// broken open marker
					cut = $urandom_range(0, 7);
					add_str(OpenMark.substr(0, cut));
				end
				6: begin
					// broken entity
					cut = $urandom_range(0, 4);
					if ($urandom_range(0, 1))
						add_str(EntQuot.substr(0, cut));
					else
						add_str(EntApos.substr(0, cut));
				end
				7: begin
					if ($urandom_range(0, 1))
						add_str("]]");
					else
						add_str("]");
				end
				8, 9, 10: repeat ($urandom_range(1, 3))
					script.push_back(8'($urandom_range(97, 122)));
				default: script.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic send_script(input bit close_it);
		foreach (script[i])
			send_text(script[i], close_it && (i == script.size() - 1), -1, 1'b0);
		if (close_it)
			strings_sent++;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		int sent;
		for (int i = 0; i < WinDepth; i++)
			pend[i] = 8'h00;

		// hold reset, then release it on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset setting (sections honored):
		// byte extremes, every special character, an entity that must not
		// be encoded twice, a closed section, and a one-byte string.
		for (int r = 0; r < NumRows; r++) begin
			for (int i = 0; i < rows[r].n; i++)
				send_text(rows[r].txt[8 * (rows[r].n - 1 - i) +: 8],
					i == rows[r].n - 1, r, i == 0);
			strings_sent++;
		end

		// Random phases alternate the section setting, both values.
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_aware(ph[0]);
			if (ph == 2) begin
				// Finish the string left open by the previous phase: the
				// section opened there stays open although sections are
				// now ignored, until its close marker.
				script.delete();
				add_str("x<]]>&y<![CDATA['");
				send_script(1'b1);
			end
			sent = 0;
			while (sent < PhaseBeats) begin
				make_text();
				calm = ($urandom_range(0, 3) == 0);
				send_script(1'b1);
				sent += script.size();
			end
			calm = 1'b0;
			if (ph == 1) begin
				// open a section and stop mid-string so the setting can
				// change under it
				script.delete();
				add_str(OpenMark);
				send_script(1'b0);
			end
		end

		settle();
		$display("Covered %0d strings, %0d text beats in, %0d escaped bytes out,",
			strings_sent, beats_in, bytes_out);
		$display("%0d section-setting writes, %0d cycles.", cfg_writes, cycles);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/xee_pkg.sv
src/xee_decide.sv
src/xee_emit.sv
src/xml_entity_escaper_cdata.sv
src/xee_checker.sv
verif/tb_xml_entity_escaper_cdata.sv
